@@ sv/aagc_pkg.sv @@
// Shared types, constants and constant tables for the sample gain control block.
`default_nettype none
package aagc_pkg;

  localparam int LOG_TABLE_BITS = 8;
  localparam int ROOT_STEPS     = 16;
  localparam int ITER_W         = $clog2(ROOT_STEPS);
  localparam int L_W            = LOG_TABLE_BITS + 6;
  localparam int D_W            = L_W + 17;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [23:0] INIT_GAIN_RST  = 24'd65536;
  localparam logic [23:0] MAX_GAIN_RST   = 24'd207243;
  localparam logic [23:0] MIN_GAIN_RST   = 24'd20724;
  localparam logic [31:0] INV_TARGET_RST = 32'd145708;
  localparam logic [15:0] ALPHA_RST      = 16'd655;
  localparam logic [31:0] ENERGY_ONE     = 32'h0100_0000;
  localparam logic [31:0] ENERGY_FLOOR   = 32'd16;
  localparam logic [30:0] Q30_ONE        = 31'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_GAIN  = 3'd0,
    REG_MAX_GAIN   = 3'd1,
    REG_MIN_GAIN   = 3'd2,
    REG_INV_TARGET = 3'd3,
    REG_ALPHA      = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MULP, ST_MULA, ST_MULB, ST_INST, ST_EN1, ST_EN2, ST_EN3,
    ST_LOGN, ST_SQ, ST_SCALE, ST_YCALC, ST_EXP, ST_GMUL, ST_CLAMP, ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MULP, OP_MULA, OP_MULB, OP_INST, OP_EN1, OP_EN2, OP_EN3,
    OP_LOGN, OP_SQ, OP_SCALE, OP_YCALC, OP_EXP, OP_GMUL, OP_CLAMP, OP_OUT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ITER_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic energy_big;
  } sts_t;

  typedef logic [31:0] root_tbl_t [ROOT_STEPS];

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] xv;
    res   = '0;
    bit_v = 64'd1 << 62;
    xv    = x;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > xv) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 0) begin
        if (xv >= res + bit_v) begin
          xv  = xv - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // Chained square roots of two, Q1.30: 2^(1/2), 2^(1/4), ...
  function automatic root_tbl_t build_roots();
    root_tbl_t   t;
    logic [63:0] root;
    root = isqrt64(64'd2 << 60);
    for (int j = 0; j < ROOT_STEPS; j++) begin
      t[j] = root[31:0];
      root = isqrt64(root << 30);
    end
    return t;
  endfunction

  localparam root_tbl_t ROOT_ROM = build_roots();

endpackage
`default_nettype wire

@@ sv/aagc_if.sv @@
// Stream interfaces for input samples and gained results.
`default_nettype none
interface aagc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  logic               last_in_block;
  modport source (output valid, sample_in, last_in_block, input ready);
  modport sink   (input valid, sample_in, last_in_block, output ready);
endinterface

interface aagc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic        [23:0] gain_now;
  logic               last_out;
  modport source (output valid, sample_out, gain_now, last_out, input ready);
  modport sink   (input valid, sample_out, gain_now, last_out, output ready);
endinterface
`default_nettype wire

@@ sv/aagc_datapath.sv @@
// Arithmetic datapath: gain multiply, energy filter, log2 and exp2 units, clamp.
`default_nettype none
module aagc_datapath
  import aagc_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  wire signed [15:0]     in_sample_i,
  input  wire                   in_last_i,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i,
  output logic signed [15:0]    out_sample_o,
  output logic [23:0]           out_gain_o,
  output logic                  out_last_o
);

  logic [23:0] max_gain_q, min_gain_q;
  logic [31:0] inv_target_q;
  logic [15:0] alpha_q;
  logic [23:0] gain_q;
  logic [31:0] energy_q;

  logic signed [15:0] s_q;
  logic               last_q;
  logic [39:0]        mag_q;
  logic signed [15:0] q_q;
  logic [55:0]        a_q, b_q;
  logic [31:0]        inst_q;
  logic [48:0]        t1_q;
  logic [47:0]        t2_q;
  logic [30:0]        m_q;
  logic [LOG_TABLE_BITS-1:0] frac_q;
  logic signed [5:0]  nint_q;
  logic signed [D_W-1:0] d_q;
  logic signed [23:0] y_q;
  logic [30:0]        r_q;
  logic [54:0]        prod_q;

  // product and saturation
  logic signed [40:0] p_s;
  logic [39:0]        mag_d;
  logic [23:0]        qmag;
  logic signed [15:0] q_d;

  always_comb begin
    p_s   = s_q * $signed({1'b0, gain_q});
    mag_d = p_s[40] ? 40'(-p_s) : p_s[39:0];
    qmag  = mag_d[39:16];
    if (!p_s[40]) begin
      q_d = (qmag > 24'd32767) ? 16'sd32767 : $signed(qmag[15:0]);
    end else begin
      q_d = (qmag > 24'd32768) ? -16'sd32768 : $signed(16'(-qmag[15:0]));
    end
  end

  // instant energy
  logic [56:0] inst_sum;
  always_comb begin
    inst_sum = 57'(a_q >> 4) + 57'((({52'd0, a_q[3:0]} << 16) + b_q) >> 20);
  end

  // leading one and mantissa
  logic [4:0]  lead_n;
  logic [31:0] norm;
  always_comb begin
    lead_n = '0;
    for (int i = 0; i < 32; i++) begin
      if (energy_q[i]) lead_n = 5'(i);
    end
    norm = energy_q << (5'd31 - lead_n);
  end

  logic [61:0] sq;
  logic [61:0] rr;
  logic [30:0] root_sel;
  logic [15:0] f_bits;
  always_comb begin
    sq       = 62'(m_q) * 62'(m_q);
    root_sel = ROOT_ROM[cmd_i.idx][30:0];
    rr       = 62'(r_q) * 62'(root_sel);
    f_bits   = y_q[15:0];
  end

  logic signed [L_W-1:0] l_val;
  logic signed [D_W:0]   nd;
  logic signed [D_W:0]   y_full;
  always_comb begin
    l_val  = $signed({nint_q, frac_q});
    nd     = -$signed({d_q[D_W-1], d_q});
    y_full = nd >>> (LOG_TABLE_BITS + 1);
  end

  // k spans about +-12, so the shift 30-k stays well inside 0..63
  logic signed [7:0] k_s;
  logic signed [8:0] sh_s;
  logic [54:0]       g_upd;
  logic [54:0]       g_src;
  logic [23:0]       g_cl;
  always_comb begin
    k_s   = y_q[23:16];
    sh_s  = 9'sd30 - {k_s[7], k_s};
    g_upd = prod_q >> sh_s[5:0];
    g_src = sts_o.energy_big ? g_upd : {31'd0, gain_q};
    if (g_src > {31'd0, max_gain_q})      g_cl = max_gain_q;
    else if (g_src < {31'd0, min_gain_q}) g_cl = min_gain_q;
    else                                  g_cl = g_src[23:0];
  end

  assign sts_o.energy_big = energy_q > ENERGY_FLOOR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gain_q   <= MAX_GAIN_RST;
      min_gain_q   <= MIN_GAIN_RST;
      inv_target_q <= INV_TARGET_RST;
      alpha_q      <= ALPHA_RST;
      gain_q       <= INIT_GAIN_RST;
      energy_q     <= ENERGY_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INIT_GAIN: begin
          gain_q      <= cfg_data_i[23:0];
        end
        REG_MAX_GAIN:   max_gain_q   <= cfg_data_i[23:0];
        REG_MIN_GAIN:   min_gain_q   <= cfg_data_i[23:0];
        REG_INV_TARGET: inv_target_q <= cfg_data_i;
        REG_ALPHA:      alpha_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end else begin
      if (cmd_i.op == OP_EN3)   energy_q <= 32'((t1_q + {1'b0, t2_q}) >> 16);
      if (cmd_i.op == OP_CLAMP) gain_q   <= g_cl;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        s_q    <= in_sample_i;
        last_q <= in_last_i;
      end
      OP_MULP: begin
        mag_q <= mag_d;
        q_q   <= q_d;
      end
      OP_MULA: a_q <= 56'(mag_q) * 56'(inv_target_q[31:16]);
      OP_MULB: b_q <= 56'(mag_q) * 56'(inv_target_q[15:0]);
      OP_INST: inst_q <= (inst_sum > 57'hFFFF_FFFF) ? 32'hFFFF_FFFF : inst_sum[31:0];
      OP_EN1:  t1_q <= 49'(17'h10000 - {1'b0, alpha_q}) * 49'(energy_q);
      OP_EN2:  t2_q <= 48'(alpha_q) * 48'(inst_q);
      OP_LOGN: begin
        m_q    <= norm[31:1];
        frac_q <= '0;
        nint_q <= $signed({1'b0, lead_n}) - 6'sd24;
      end
      OP_SQ: begin
        if (sq[61]) begin
          m_q    <= sq[61:31];
          frac_q <= {frac_q[LOG_TABLE_BITS-2:0], 1'b1};
        end else begin
          m_q    <= sq[60:30];
          frac_q <= {frac_q[LOG_TABLE_BITS-2:0], 1'b0};
        end
      end
      OP_SCALE: d_q <= $signed({1'b0, alpha_q}) * l_val;
      OP_YCALC: begin
        y_q <= y_full[23:0];
        r_q <= Q30_ONE;
      end
      OP_EXP: begin
        if (f_bits[ROOT_STEPS - 1 - int'(cmd_i.idx)]) r_q <= rr[60:30];
      end
      OP_GMUL: prod_q <= 55'(gain_q) * 55'(r_q);
      OP_OUT: begin
        out_sample_o <= q_q;
        out_gain_o   <= gain_q;
        out_last_o   <= last_q;
      end
      default: ;
    endcase
  end

  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SQ) |-> m_q[30])
    else $error("log2 mantissa lost its leading one");
  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EXP) |-> r_q[30])
    else $error("exp2 fraction fell below one");

endmodule
`default_nettype wire

@@ sv/aagc_ctrl.sv @@
// Sequencer: steps the datapath through one sample and owns the handshakes.
`default_nettype none
module aagc_ctrl
  import aagc_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  state_e            state_q, state_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MULP;
      ST_MULP:  state_d = ST_MULA;
      ST_MULA:  state_d = ST_MULB;
      ST_MULB:  state_d = ST_INST;
      ST_INST:  state_d = ST_EN1;
      ST_EN1:   state_d = ST_EN2;
      ST_EN2:   state_d = ST_EN3;
      ST_EN3:   state_d = ST_LOGN;
      ST_LOGN: begin
        cnt_d   = '0;
        state_d = sts_i.energy_big ? ST_SQ : ST_CLAMP;
      end
      ST_SQ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ITER_W'(LOG_TABLE_BITS - 1)) state_d = ST_SCALE;
      end
      ST_SCALE: state_d = ST_YCALC;
      ST_YCALC: begin
        cnt_d   = '0;
        state_d = ST_EXP;
      end
      ST_EXP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ITER_W'(ROOT_STEPS - 1)) state_d = ST_GMUL;
      end
      ST_GMUL:  state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.idx   = cnt_q;
    cmd_o.op    = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_MULP:  cmd_o.op = OP_MULP;
      ST_MULA:  cmd_o.op = OP_MULA;
      ST_MULB:  cmd_o.op = OP_MULB;
      ST_INST:  cmd_o.op = OP_INST;
      ST_EN1:   cmd_o.op = OP_EN1;
      ST_EN2:   cmd_o.op = OP_EN2;
      ST_EN3:   cmd_o.op = OP_EN3;
      ST_LOGN:  cmd_o.op = OP_LOGN;
      ST_SQ:    cmd_o.op = OP_SQ;
      ST_SCALE: cmd_o.op = OP_SCALE;
      ST_YCALC: cmd_o.op = OP_YCALC;
      ST_EXP:   cmd_o.op = OP_EXP;
      ST_GMUL:  cmd_o.op = OP_GMUL;
      ST_CLAMP: cmd_o.op = OP_CLAMP;
      ST_DONE: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MULP))
    else $error("accepted sample did not start the sequence");
  a_sq_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ) |-> (cnt_q < ITER_W'(LOG_TABLE_BITS)))
    else $error("squaring count overran");
  a_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not published on leaving done");

endmodule
`default_nettype wire

@@ sv/audio_agc_sample_gain.sv @@
// Top level of the audio sample gain control block.
//
//  channel  dir  transfer when        payload
//  in_i     in   valid & ready        sample_in[15:0] signed, last_in_block
//  out_o    out  valid & ready        sample_out[15:0] signed, gain_now[23:0], last_out
//  cfg      in   cfg_we_i             cfg_idx_i[2:0], cfg_data_i[31:0]
//
// One sample is stepped through the datapath from its transfer to its result
// (the log2 and exp2 steps are skipped when the energy is at or below the floor).
// The log2 and exp2 units run 8 squarings and 16 root steps through
// one shared multiplier each, one per cycle.
// Reset (rst_ni low, asynchronous) loads the sequencer state and the configuration
// registers with their defaults, gain with the initial gain and the energy estimate with 1.0.
// The result sits in an output register; the next sample is taken while it
// waits. A stalled output holds the sequence only at its final step.
`default_nettype none
module audio_agc_sample_gain
  import aagc_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  aagc_in_if.sink              in_i,
  aagc_out_if.source           out_o,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns valid/ready on both channels
  aagc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: config registers, gain and energy state, arithmetic units
  aagc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_sample_i  (in_i.sample_in),
    .in_last_i    (in_i.last_in_block),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_sample_o (out_o.sample_out),
    .out_gain_o   (out_o.gain_now),
    .out_last_o   (out_o.last_out)
  );

endmodule
`default_nettype wire
